// ----- design/phase_vocoder_bin_converter_defines.svh -----
// assertion macros used by the checker file
`ifndef PHASE_VOCODER_BIN_CONVERTER_DEFINES_SVH
`define PHASE_VOCODER_BIN_CONVERTER_DEFINES_SVH

// next-cycle implication, masked while reset is low
`define PVBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that is also checked across reset
`define PVBC_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/pvbc_pkg.sv -----
// shared constants, types and tables of the bin converter
`timescale 1ns / 1ps
`default_nettype none

package pvbc_pkg;

    localparam int MAX_HALF_SIZE_DEF = 512;
    localparam int PHASE_BITS_DEF    = 16;

    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_W     = 35;
    localparam int ANGLE_W      = 32;
    localparam int SQRT_STEPS   = 24;
    localparam int SQ_W         = 48;

    localparam int CH_W     = 10;
    localparam int BIN_W    = 10;
    localparam int SAMPLE_W = 24;
    localparam int HALF_W   = 10;
    localparam int HOP_W    = 26;
    localparam int SPC_W    = 25;
    localparam int MAG_W    = 24;
    localparam int FREQ_W   = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 26;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 72;

    localparam logic [HALF_W-1:0] HALF_SIZE_RST = 10'd512;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_SIZE   = 2'd0,
        REG_HOP_RATE    = 2'd1,
        REG_BIN_SPACING = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic             valid;
        logic [CH_W-1:0]  ch;
        logic [BIN_W-1:0] bin;
        logic             first;
        logic             in_store;
    } t_meta;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [ANGLE_W-1:0] angle_at(input int i);
        logic [ANGLE_W-1:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- design/pvbc_cordic.sv -----
// pipelined cordic vectoring, one micro-rotation per register stage
`timescale 1ns / 1ps
`default_nettype none

module pvbc_cordic (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_en,
    input  wire logic signed [pvbc_pkg::CORDIC_W-1:0] i_x,
    input  wire logic signed [pvbc_pkg::CORDIC_W-1:0] i_y,
    input  wire logic        [pvbc_pkg::ANGLE_W-1:0]  i_z,
    output logic             [pvbc_pkg::ANGLE_W-1:0]  o_z
);

    localparam int STEPS = pvbc_pkg::CORDIC_STEPS;
    localparam int W     = pvbc_pkg::CORDIC_W;

    logic signed [W-1:0]                  r_x [0:STEPS-1];
    logic signed [W-1:0]                  r_y [0:STEPS-1];
    logic [pvbc_pkg::ANGLE_W-1:0]         r_z [0:STEPS-1];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic signed [W-1:0]          x_in;
        logic signed [W-1:0]          y_in;
        logic [pvbc_pkg::ANGLE_W-1:0] z_in;

        if (k == 0) begin : g_head
            assign x_in = i_x;
            assign y_in = i_y;
            assign z_in = i_z;
        end else begin : g_body
            assign x_in = r_x[k-1];
            assign y_in = r_y[k-1];
            assign z_in = r_z[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (y_in > 0) begin
                    r_x[k] <= x_in + (y_in >>> k);
                    r_y[k] <= y_in - (x_in >>> k);
                    r_z[k] <= z_in + pvbc_pkg::angle_at(k);
                end else begin
                    r_x[k] <= x_in - (y_in >>> k);
                    r_y[k] <= y_in + (x_in >>> k);
                    r_z[k] <= z_in - pvbc_pkg::angle_at(k);
                end
            end
        end
    end

    assign o_z = r_z[STEPS-1];

endmodule

`default_nettype wire

// ----- design/pvbc_sqrt.sv -----
// pipelined magnitude: squares, sum, one root bit per stage, saturation
`timescale 1ns / 1ps
`default_nettype none

module pvbc_sqrt (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_en,
    input  wire logic signed [pvbc_pkg::SAMPLE_W-1:0] i_a,
    input  wire logic signed [pvbc_pkg::SAMPLE_W-1:0] i_b,
    output logic             [pvbc_pkg::MAG_W-1:0]    o_mag
);

    localparam int STEPS = pvbc_pkg::SQRT_STEPS;
    localparam int SW    = pvbc_pkg::SQ_W;
    localparam int MW    = pvbc_pkg::MAG_W;

    logic [SW-1:0] r_sa;
    logic [SW-1:0] r_sb;
    logic [SW-1:0] r_sum;
    logic [SW-1:0] r_rem [0:STEPS-1];
    logic [SW-1:0] r_res [0:STEPS-1];
    logic [MW-1:0] r_sat;
    logic [MW-1:0] r_mag;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sa  <= SW'(i_a * i_a);
            r_sb  <= SW'(i_b * i_b);
            r_sum <= r_sa + r_sb;
        end
    end

    for (genvar j = 0; j < STEPS; j++) begin : g_bit
        localparam logic [SW-1:0] BIT = SW'(1) << (2 * (STEPS - 1 - j));
        logic [SW-1:0] rem_in;
        logic [SW-1:0] res_in;
        logic [SW-1:0] trial;

        if (j == 0) begin : g_head
            assign rem_in = r_sum;
            assign res_in = '0;
        end else begin : g_body
            assign rem_in = r_rem[j-1];
            assign res_in = r_res[j-1];
        end

        assign trial = res_in + BIT;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_in >= trial) begin
                    r_rem[j] <= rem_in - trial;
                    r_res[j] <= (res_in >> 1) + BIT;
                end else begin
                    r_rem[j] <= rem_in;
                    r_res[j] <= res_in >> 1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat <= (r_res[STEPS-1] > SW'({MW{1'b1}})) ? {MW{1'b1}}
                                                       : r_res[STEPS-1][MW-1:0];
            r_mag <= r_sat;
        end
    end

    assign o_mag = r_mag;

endmodule

`default_nettype wire

// ----- design/phase_vocoder_bin_converter.sv -----
// an accepted item moves through stage 0, the 28-stage cordic and the root pipelines,
// stages 29 to 31 with the phase store access, and the output register
// throughput: one item per cycle; a stalled output freezes the whole pipeline
// reset: config registers return to defaults, then a clearing pass over all
// MAX_HALF_SIZE+1 entries zeroes the phase store; no item is taken until it ends
// top level of the bin converter: magnitude and instantaneous frequency
`timescale 1ns / 1ps
`default_nettype none

module phase_vocoder_bin_converter #(
    parameter int MAX_HALF_SIZE = pvbc_pkg::MAX_HALF_SIZE_DEF,
    parameter int PHASE_BITS    = pvbc_pkg::PHASE_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // input items
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // channel[9:0], bin[19:10], re_in[43:20], im_in[67:44], zero pad
    input  wire logic [pvbc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // first_frame
    input  wire logic                                  s_axis_tuser,
    // result items
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // out_bin[9:0], magnitude[33:10], frequency_q8[65:34], zero pad
    output logic [pvbc_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
    // register writes
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [pvbc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [pvbc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int PB     = PHASE_BITS;
    localparam int DEPTH  = MAX_HALF_SIZE + 1;
    localparam int AW     = $clog2(DEPTH);
    localparam int NC     = pvbc_pkg::CORDIC_STEPS;
    localparam int CW     = pvbc_pkg::CORDIC_W;
    localparam int ZW     = pvbc_pkg::ANGLE_W;
    localparam int SMW    = pvbc_pkg::SAMPLE_W;
    localparam int MW     = pvbc_pkg::MAG_W;
    localparam int BPW    = pvbc_pkg::BIN_W + pvbc_pkg::SPC_W;
    localparam int PRW    = PB + pvbc_pkg::HOP_W + 1;
    localparam int FSW    = PB + pvbc_pkg::HOP_W + 3;
    localparam int FW     = pvbc_pkg::FREQ_W;

    localparam logic signed [FSW-1:0] ROUND_HALF = FSW'(1) << (PB - 1);
    localparam logic signed [FSW-1:0] F_MAX      = FSW'(32'h7FFF_FFFF);
    localparam logic signed [FSW-1:0] F_MIN      = -F_MAX - FSW'(1);

    // configuration registers
    logic [pvbc_pkg::HALF_W-1:0] r_half;
    logic [pvbc_pkg::HOP_W-1:0]  r_hop;
    logic [pvbc_pkg::SPC_W-1:0]  r_spc;

    // clearing pass over the phase store
    logic          r_clearing;
    logic [AW-1:0] r_clr;

    // pipeline control: the whole pipe moves when the output register can move
    logic en;
    logic accept;

    // input side decode
    logic [pvbc_pkg::CH_W-1:0]  in_ch;
    logic [pvbc_pkg::BIN_W-1:0] in_bin;
    logic signed [SMW-1:0]      in_re;
    logic signed [SMW-1:0]      in_im;
    logic signed [SMW-1:0]      in_im_eff;
    logic signed [CW-1:0]       in_x;
    logic signed [CW-1:0]       in_y;

    // stage 0 and the meta line that rides beside the cordic and root pipes
    pvbc_pkg::t_meta        r_meta [0:NC];
    logic signed [CW-1:0]   r_x0;
    logic signed [CW-1:0]   r_y0;
    logic [ZW-1:0]          r_z0;
    logic signed [SMW-1:0]  r_a0;
    logic signed [SMW-1:0]  r_b0;

    logic [ZW-1:0]          cordic_z;
    logic [MW-1:0]          root;
    logic [ZW-1:0]          z_neg;
    logic [ZW-1:0]          z_rnd;
    logic [PB-1:0]          ph28;

    // stage 29: phase, magnitude, previous phase
    pvbc_pkg::t_meta        r_m29;
    logic [PB-1:0]          r_ph29;
    logic [MW-1:0]          r_mag29;
    logic [PB-1:0]          r_prev29;
    logic                   mag_zero29;
    logic                   wr29;
    logic [PB-1:0]          wr_val29;
    logic [PB-1:0]          prev_eff29;
    logic                   fwd28;
    logic [AW-1:0]          addr28;
    logic [AW-1:0]          addr29;
    logic [PB-1:0]          r_mem [0:DEPTH-1];

    // stages 30 and 31
    logic                   r_v30;
    logic [pvbc_pkg::BIN_W-1:0] r_bin30;
    logic signed [PB-1:0]   r_diff30;
    logic [BPW-1:0]         r_binp30;
    logic [MW-1:0]          r_mag30;
    logic                   r_v31;
    logic [pvbc_pkg::BIN_W-1:0] r_bin31;
    logic signed [PRW-1:0]  r_prod31;
    logic [BPW-1:0]         r_binp31;
    logic [MW-1:0]          r_mag31;

    // output register
    logic signed [FSW-1:0]  f_biased;
    logic signed [FSW-1:0]  f_sum;
    logic [FW-1:0]          f_sat;
    logic                   r_out_v;
    logic [pvbc_pkg::BIN_W-1:0] r_out_bin;
    logic [MW-1:0]          r_out_mag;
    logic [FW-1:0]          r_out_freq;

    assign en            = !r_out_v || m_axis_tready;
    assign s_axis_tready = en && !r_clearing;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // config writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= pvbc_pkg::HALF_SIZE_RST;
            r_hop  <= '0;
            r_spc  <= '0;
        end else if (i_cfg_valid) begin
            case (pvbc_pkg::t_cfg_reg'(i_cfg_index))
                pvbc_pkg::REG_HALF_SIZE:   r_half <= i_cfg_data[pvbc_pkg::HALF_W-1:0];
                pvbc_pkg::REG_HOP_RATE:    r_hop  <= i_cfg_data[pvbc_pkg::HOP_W-1:0];
                pvbc_pkg::REG_BIN_SPACING: r_spc  <= i_cfg_data[pvbc_pkg::SPC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr      <= '0;
        end else if (r_clearing) begin
            if (r_clr == AW'(MAX_HALF_SIZE)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr <= r_clr + AW'(1);
            end
        end
    end

    // unpack and pre-rotate: a negative real part turns by a half turn
    assign in_ch     = s_axis_tdata[9:0];
    assign in_bin    = s_axis_tdata[19:10];
    assign in_re     = s_axis_tdata[43:20];
    assign in_im     = s_axis_tdata[67:44];
    // dc and nyquist bins carry no imaginary part
    assign in_im_eff = (in_bin == '0 || in_bin == r_half) ? '0 : in_im;
    assign in_x      = CW'(in_re) <<< 8;
    assign in_y      = CW'(in_im_eff) <<< 8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NC; i++) begin
                r_meta[i] <= '0;
            end
        end else if (en) begin
            r_meta[0].valid    <= accept;
            r_meta[0].ch       <= in_ch;
            r_meta[0].bin      <= in_bin;
            r_meta[0].first    <= s_axis_tuser;
            r_meta[0].in_store <= (32'(in_ch) <= 32'(MAX_HALF_SIZE));
            for (int i = 1; i <= NC; i++) begin
                r_meta[i] <= r_meta[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a0 <= in_re;
            r_b0 <= in_im_eff;
            if (in_re < 0) begin
                r_x0 <= -in_x;
                r_y0 <= -in_y;
                r_z0 <= 32'h8000_0000;
            end else begin
                r_x0 <= in_x;
                r_y0 <= in_y;
                r_z0 <= '0;
            end
        end
    end

    pvbc_cordic u_cordic (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r_x0),
        .i_y   (r_y0),
        .i_z   (r_z0),
        .o_z   (cordic_z)
    );

    pvbc_sqrt u_sqrt (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_a0),
        .i_b   (r_b0),
        .o_mag (root)
    );

    // phase is minus the angle, rounded to PB bits modulo one turn
    assign z_neg = '0 - cordic_z;
    assign z_rnd = z_neg + (ZW'(1) << (ZW - 1 - PB));
    assign ph28  = z_rnd[ZW-1 -: PB];

    // phase store: read entering stage 29, written when stage 29 moves on
    assign addr28     = AW'(r_meta[NC].ch);
    assign addr29     = AW'(r_m29.ch);
    assign mag_zero29 = (r_mag29 == '0);
    assign wr29       = r_m29.in_store && (!mag_zero29 || r_m29.first);
    assign wr_val29   = mag_zero29 ? '0 : r_ph29;
    // the item ahead writes the same slot on this edge
    assign fwd28      = r_m29.valid && wr29 && (r_m29.ch == r_meta[NC].ch);
    assign prev_eff29 = (r_m29.first || !r_m29.in_store) ? '0 : r_prev29;

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr] <= '0;
        end else if (en && r_m29.valid && wr29) begin
            r_mem[addr29] <= wr_val29;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prev29 <= fwd28 ? wr_val29 : r_mem[addr28];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m29 <= '0;
            r_v30 <= 1'b0;
            r_v31 <= 1'b0;
        end else if (en) begin
            r_m29 <= r_meta[NC];
            r_v30 <= r_m29.valid;
            r_v31 <= r_v30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ph29   <= ph28;
            r_mag29  <= root;
            // wraparound of the PB-bit difference does the unwrapping
            r_diff30 <= mag_zero29 ? '0 : $signed(r_ph29 - prev_eff29);
            r_binp30 <= BPW'(r_m29.bin) * BPW'(r_spc);
            r_bin30  <= r_m29.bin;
            r_mag30  <= r_mag29;
            r_prod31 <= r_diff30 * $signed({1'b0, r_hop});
            r_binp31 <= r_binp30;
            r_bin31  <= r_bin30;
            r_mag31  <= r_mag30;
        end
    end

    // round to nearest, ties up, then add the bin center and saturate
    assign f_biased = FSW'(r_prod31) + ROUND_HALF;
    assign f_sum    = (f_biased >>> PB) + $signed(FSW'(r_binp31));
    always_comb begin
        if (f_sum > F_MAX) begin
            f_sat = F_MAX[FW-1:0];
        end else if (f_sum < F_MIN) begin
            f_sat = F_MIN[FW-1:0];
        end else begin
            f_sat = f_sum[FW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_v31;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_bin  <= r_bin31;
            r_out_mag  <= r_mag31;
            r_out_freq <= f_sat;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {6'b0, r_out_freq, r_out_mag, r_out_bin};

endmodule

`default_nettype wire

// ----- design/pvbc_checker.sv -----
// port-level checks of the bin converter and their bind
`timescale 1ns / 1ps
`default_nettype none

`include "phase_vocoder_bin_converter_defines.svh"

module pvbc_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                s_axis_tvalid,
    input wire logic                                s_axis_tready,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [pvbc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input wire logic                                o_cfg_ready
);

    // a held result keeps its value until taken
    `PVBC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // the store clearing pass follows reset, so no item is taken next
    `PVBC_ASSERT_ALWAYS(a_no_take_after_reset, i_clk, !i_rst_n, !s_axis_tready, "item taken right after reset")

    // the pipeline is empty after reset
    `PVBC_ASSERT_ALWAYS(a_no_result_after_reset, i_clk, !i_rst_n, !m_axis_tvalid, "result shown right after reset")

    // a stalled output freezes the input side too
    `PVBC_ASSERT_NEXT(a_stall_blocks_input, i_clk, i_rst_n, o_cfg_ready, !(m_axis_tvalid && !m_axis_tready && s_axis_tready), "input taken while output stalled")

endmodule

bind phase_vocoder_bin_converter pvbc_checker u_pvbc_checker (.*);

`default_nettype wire

// ----- tb/tb_top.sv -----
// self-checking bench of the bin converter: predicted results against the result stream
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

    localparam int STORE_DEPTH = pvbc_pkg::MAX_HALF_SIZE_DEF + 1;
    localparam int PB          = pvbc_pkg::PHASE_BITS_DEF;
    localparam int LATENCY     = 33;
    localparam int HOLD_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 400000;

    // one input item as the feeder sees it
    typedef struct {
        logic [pvbc_pkg::CH_W-1:0]            channel;
        logic [pvbc_pkg::BIN_W-1:0]           bin;
        logic signed [pvbc_pkg::SAMPLE_W-1:0] re_in;
        logic signed [pvbc_pkg::SAMPLE_W-1:0] im_in;
        logic                                 first_frame;
    } t_bin_item;

    // one expected result
    typedef struct {
        logic [pvbc_pkg::BIN_W-1:0]         out_bin;
        logic [pvbc_pkg::MAG_W-1:0]         magnitude;
        logic signed [pvbc_pkg::FREQ_W-1:0] frequency_q8;
    } t_bin_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [pvbc_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [pvbc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [pvbc_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [pvbc_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    phase_vocoder_bin_converter u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // predictor state: registers and stored phase per channel
    logic [pvbc_pkg::HALF_W-1:0] half_size_q = pvbc_pkg::HALF_SIZE_RST;
    logic [pvbc_pkg::HOP_W-1:0]  hop_rate_q = '0;
    logic [pvbc_pkg::SPC_W-1:0]  spacing_q = '0;
    logic [PB-1:0]     phase_store [STORE_DEPTH] = '{default: '0};

    t_bin_item   pending_items[$];
    t_bin_result expected_bins[$];
    int  errors = 0;
    longint cycle_count = 0;
    bit  hold_off = 1'b0;
    bit  hold_used = 1'b0;
    int  hold_left = 0;
    bit  in_taken = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  stall_phase = 0;

    function automatic longint shift_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // atan table, units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [pvbc_pkg::CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005};

    function automatic logic [31:0] vector_angle(longint a, longint b);
        longint x, y, nx;
        logic [31:0] z;
        x = a * 256;
        y = b * 256;
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < pvbc_pkg::CORDIC_STEPS; i++) begin
            if (y > 0) begin
                nx = x + shift_floor(y, i);
                y = y - shift_floor(x, i);
                z = z + ATAN_TURNS[i];
            end else begin
                nx = x - shift_floor(y, i);
                y = y + shift_floor(x, i);
                z = z - ATAN_TURNS[i];
            end
            x = nx;
        end
        return z;
    endfunction

    // magnitude and instantaneous frequency of one bin, updates the phase store
    function automatic t_bin_result convert_bin(t_bin_item it);
        t_bin_result r;
        longint a, b, diff, freq;
        logic [63:0] mag;
        logic [PB-1:0] prev, ph, d;
        logic [31:0] z;
        bit in_store;
        a = it.re_in;
        b = it.im_in;
        diff = 0;
        in_store = it.channel < STORE_DEPTH;
        if (it.bin == 0 || it.bin == half_size_q) b = 0;
        mag = root_floor(64'(a * a) + 64'(b * b));
        if (mag > 64'hFFFFFF) mag = 64'hFFFFFF;
        prev = (in_store && !it.first_frame) ? phase_store[it.channel] : '0;
        if (mag == 0) begin
            // nothing to measure: stored phase kept, cleared on a first frame
            if (in_store && it.first_frame) phase_store[it.channel] = '0;
        end else begin
            z = 32'd0 - vector_angle(a, b);
            ph = PB'((z + (32'd1 << (31 - PB))) >> (32 - PB));
            d = ph - prev;
            diff = longint'($signed(d));
            if (in_store) phase_store[it.channel] = ph;
        end
        freq = shift_floor(diff * longint'(hop_rate_q) + (longint'(1) << (PB - 1)), PB)
             + longint'(it.bin) * longint'(spacing_q);
        if (freq > 64'sd2147483647) freq = 64'sd2147483647;
        if (freq < -64'sd2147483648) freq = -64'sd2147483648;
        r.out_bin = it.bin;
        r.magnitude = mag[pvbc_pkg::MAG_W-1:0];
        r.frequency_q8 = freq[31:0];
        return r;
    endfunction

    // input handshake at the rising edge: the accepted item goes to the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_bins.push_back(convert_bin(pending_items.pop_front()));
            in_taken <= 1'b1;
        end else begin
            in_taken <= 1'b0;
        end
    end

    // driver: bursts of valid items with random gaps, offered item held until taken
    always @(negedge i_clk) begin
        if (!s_axis_tvalid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {4'd0, pending_items[0].im_in, pending_items[0].re_in,
                                 pending_items[0].bin, pending_items[0].channel};
                s_axis_tuser <= pending_items[0].first_frame;
                if (burst_left > 0) burst_left--;
                else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, with one long hold-off counted here
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (hold_off && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if ((stall_phase / 64) % 3 == 2) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) < 70);
        end
    end

    // monitor: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_bin_result e;
        logic [pvbc_pkg::BIN_W-1:0] a_bin;
        logic [pvbc_pkg::MAG_W-1:0] a_mag;
        logic [pvbc_pkg::FREQ_W-1:0] a_freq;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            a_bin = m_axis_tdata[9:0];
            a_mag = m_axis_tdata[33:10];
            a_freq = m_axis_tdata[65:34];
            if (expected_bins.size() == 0) begin
                $error("result with nothing expected: bin %0d", a_bin);
                errors++;
            end else begin
                e = expected_bins.pop_front();
                if (a_bin !== e.out_bin) begin
                    $error("out_bin expected %0d actual %0d", e.out_bin, a_bin);
                    errors++;
                end
                if (a_mag !== e.magnitude) begin
                    $error("magnitude expected %0d actual %0d", e.magnitude, a_mag);
                    errors++;
                end
                if (a_freq !== e.frequency_q8) begin
                    $error("frequency_q8 expected %0d actual %0d", e.frequency_q8,
                           $signed(a_freq));
                    errors++;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic write_reg(pvbc_pkg::t_cfg_reg idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= pvbc_pkg::CFG_DATA_W'(val);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            pvbc_pkg::REG_HALF_SIZE:   half_size_q = pvbc_pkg::HALF_W'(val);
            pvbc_pkg::REG_HOP_RATE:    hop_rate_q = pvbc_pkg::HOP_W'(val);
            pvbc_pkg::REG_BIN_SPACING: spacing_q = pvbc_pkg::SPC_W'(val);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_bin(int ch, int bn, int re, int im, bit ff);
        t_bin_item it;
        it.channel = pvbc_pkg::CH_W'(ch);
        it.bin = pvbc_pkg::BIN_W'(bn);
        it.re_in = pvbc_pkg::SAMPLE_W'(re);
        it.im_in = pvbc_pkg::SAMPLE_W'(im);
        it.first_frame = ff;
        pending_items.push_back(it);
    endtask

    function automatic int rand_sample();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 15) - 8;
            1: return ($urandom_range(0, 1) ? 8388607 : -8388608) + $urandom_range(0, 3)
                      * ($urandom_range(0, 1) ? 1 : 0);
            default: return int'($signed(24'($urandom)));
        endcase
    endfunction

    task automatic drain();
        while (pending_items.size() > 0 || expected_bins.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // random frames: channels walk bins of one setting, with noise items mixed in
    task automatic random_frames(int n);
        int k;
        bit ff;
        k = 0;
        ff = 1'b1;
        while (k < n) begin
            for (int c = 0; c <= half_size_q && k < n; c++) begin
                if ($urandom_range(0, 9) == 0)
                    add_bin($urandom_range(0, 1023), $urandom_range(0, 1023),
                            rand_sample(), rand_sample(), ($urandom_range(0, 1) == 1));
                else
                    add_bin(c, (c * 7) % (half_size_q + 1), rand_sample(),
                            rand_sample(), ff);
                k++;
            end
            ff = ($urandom_range(0, 7) == 0);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, dc and nyquist, zero magnitude, out-of-store slot
        write_reg(pvbc_pkg::REG_HOP_RATE, 3000000);
        write_reg(pvbc_pkg::REG_BIN_SPACING, 12345);
        add_bin(0, 0, 8388607, 8388607, 1);
        add_bin(1, 512, -8388608, -8388608, 1);
        add_bin(2, 2, -8388608, -8388608, 1);
        add_bin(2, 2, -8388608, 8388607, 0);
        add_bin(3, 3, -1, 0, 1);
        add_bin(3, 3, 1, 0, 0);
        add_bin(4, 4, 0, 0, 0);
        add_bin(4, 4, 0, 0, 1);
        add_bin(5, 5, 0, 5, 0);
        add_bin(5, 5, 0, -5, 0);
        add_bin(1023, 1023, 123456, -654321, 0);
        add_bin(513, 700, -4, 3, 1);
        add_bin(512, 511, 8388607, -8388608, 0);
        add_bin(6, 6, 'h2AAAAA, -'h155556, 0);
        drain();

        // small half size, large hop rate and bin spacing
        write_reg(pvbc_pkg::REG_HALF_SIZE, 1);
        write_reg(pvbc_pkg::REG_HOP_RATE, 50331647);
        write_reg(pvbc_pkg::REG_BIN_SPACING, 25165823);
        random_frames(250);
        drain();
        write_reg(pvbc_pkg::REG_HALF_SIZE, 512);
        write_reg(pvbc_pkg::REG_HOP_RATE, 0);
        write_reg(pvbc_pkg::REG_BIN_SPACING, 0);
        random_frames(300);
        // long receiver hold-off so the pipeline backs up into the input
        hold_off = 1'b1;
        drain();
        write_reg(pvbc_pkg::REG_HALF_SIZE, $urandom_range(2, 100));
        write_reg(pvbc_pkg::REG_HOP_RATE, $urandom_range(0, 50331647));
        write_reg(pvbc_pkg::REG_BIN_SPACING, $urandom_range(0, 25165823));
        random_frames(400);
        drain();
        write_reg(pvbc_pkg::REG_HALF_SIZE, 17);
        write_reg(pvbc_pkg::REG_HOP_RATE, 11264000);
        write_reg(pvbc_pkg::REG_BIN_SPACING, 2822400);
        random_frames(400);
        drain();

        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
